// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the span stepper modules.
// Expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/psts_pkg.sv =====
// Package for the perspective span texel stepper.
// Holds command codes, register indexes, micro-op codes and the
// controller/datapath structs; no dependencies.
package psts_pkg;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_STEP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_U_STEP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_V_STEP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AFFINE_MODE = 3'd4;

   localparam logic [31:0] DEPTH_SCALE_RESET = 32'h0001_0000;
   localparam int DIV_NUM_W = 48;
   localparam int DIV_CNT_W = 6;
   localparam int OFFSET_W  = 10;
   localparam int TEXEL_LSB = 17;
   localparam int TEXEL_W   = 7;

   typedef logic [4:0] op_type;
   localparam op_type OP_NONE      = 5'd0;
   localparam op_type OP_ACCEPT    = 5'd1;
   localparam op_type OP_DIV_RUN   = 5'd2;
   localparam op_type OP_DIV_WAIT  = 5'd3;
   localparam op_type OP_MUL_RU    = 5'd4;
   localparam op_type OP_MUL_RV_U1 = 5'd5;
   localparam op_type OP_MUL_SD_V1 = 5'd6;
   localparam op_type OP_MUL_SU_RD = 5'd7;
   localparam op_type OP_MUL_SV_RU = 5'd8;
   localparam op_type OP_RV_DIV    = 5'd9;
   localparam op_type OP_MUL_RV_DU = 5'd10;
   localparam op_type OP_DV        = 5'd11;
   localparam op_type OP_SHIFT     = 5'd12;
   localparam op_type OP_DIV_INV   = 5'd13;
   localparam op_type OP_MUL_DU    = 5'd14;
   localparam op_type OP_MUL_DV_TU = 5'd15;
   localparam op_type OP_SETV      = 5'd16;
   localparam op_type OP_EMIT      = 5'd17;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic pix_empty;
      logic sub_zero;
      logic affine;
      logic full_sub;
      logic div_done;
   } dp_status_type;

endpackage

// ===== hdl/psts_div.sv =====
// Iterative signed divider, one quotient bit per cycle, with optional
// round-to-nearest-even and 32-bit saturation. Uses psts_pkg.
`include "assert_macros.svh"
module psts_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   round_en,
   input  logic signed [psts_pkg::DIV_NUM_W-1:0]  num,
   input  logic signed [31:0]                     den,
   output logic                                   done,
   output logic [31:0]                            quot
);
   import psts_pkg::*;

   localparam int NW = DIV_NUM_W;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]        quo_ff, quo_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          m_ff;
   logic                 neg_ff, zero_ff, rnd_ff;
   logic [32:0]          rem_sh, two_r, m33;
   logic                 ge, up;
   logic [NW:0]          q_rnd;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[NW-1]};
      m33    = {1'b0, m_ff};
      ge     = rem_sh >= m33;
      rem_in = ge ? 32'(rem_sh - m33) : rem_sh[31:0];
      quo_in = {quo_ff[NW-2:0], ge};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(NW);
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= num[NW-1] ? NW'(-num) : num;
         m_ff    <= den[31] ? 32'(-den) : den;
         rem_ff  <= '0;
         neg_ff  <= num[NW-1] ^ den[31];
         zero_ff <= den == '0;
         rnd_ff  <= round_en;
      end else if (busy_ff && cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_comb begin
      two_r = {rem_ff, 1'b0};
      up    = rnd_ff && ((two_r > m33) || ((two_r == m33) && quo_ff[0]));
      q_rnd = {1'b0, quo_ff} + (NW+1)'(up);
      if (zero_ff) begin
         quot = 32'h7FFF_FFFF;
      end else if (!neg_ff) begin
         quot = (q_rnd > (NW+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_rnd[31:0];
      end else begin
         quot = (q_rnd > (NW+1)'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-q_rnd[31:0]);
      end
   end

   assign done = busy_ff && cnt_ff == '0;

   `ASSERT_SAME(a_div_start_idle, start, !busy_ff, "divider started while busy")

endmodule

// ===== hdl/psts_dp.sv =====
// Datapath of the span stepper: registers, span state, shared multiplier,
// divider and result register. Uses psts_pkg and psts_div.
module psts_dp #(
   parameter int MAX_SPAN  = 1024,
   parameter int SUB_SHIFT = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  psts_pkg::dp_cmd_type                cmd,
   output psts_pkg::dp_status_type             status,
   input  logic                                csr_we,
   input  logic [psts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                         csr_data,
   input  logic                                req_cmd,
   input  logic [10:0]                         req_span_width,
   input  logic signed [31:0]                  req_start_depth,
   input  logic signed [31:0]                  req_start_u,
   input  logic signed [31:0]                  req_start_v,
   input  logic signed [31:0]                  req_stored_depth,
   output logic [psts_pkg::OFFSET_W-1:0]       rsp_pixel_offset,
   output logic [psts_pkg::TEXEL_W-1:0]        rsp_texel_x,
   output logic [psts_pkg::TEXEL_W-1:0]        rsp_texel_y,
   output logic signed [31:0]                  rsp_pixel_depth,
   output logic                                rsp_write_pixel,
   output logic                                rsp_last_pixel
);
   import psts_pkg::*;

   localparam int PW       = $clog2(MAX_SPAN + 1);
   localparam int SW       = SUB_SHIFT + 1;
   localparam int SUB_SIZE = 1 << SUB_SHIFT;

   logic signed [31:0] depth_step_ff, u_step_ff, v_step_ff, depth_scale_ff;
   logic               affine_ff;
   logic signed [31:0] run_depth_ff, run_u_ff, run_v_ff;
   logic signed [31:0] tex_u_ff, tex_v_ff, tex_du_ff, tex_dv_ff, pix_depth_ff;
   logic [PW-1:0]      pixels_left_ff;
   logic [SW-1:0]      sub_left_ff, len_ff, len_in;
   logic [OFFSET_W-1:0] offset_ff;
   logic signed [31:0] stored_ff, z_ff, u1_ff, v1_ff, diffu_ff, diffv_ff;
   logic signed [31:0] mul_a, mul_b, p_hi, p_lo;
   logic signed [63:0] p_ff, p_in;
   logic [31:0]        pl32, w32, div_quot;
   logic               full_in, div_start, div_round, div_done;
   logic signed [DIV_NUM_W-1:0] div_num;
   logic signed [31:0] div_den;

   assign pl32    = 32'(pixels_left_ff);
   assign full_in = pl32 >= 32'(SUB_SIZE);
   assign len_in  = full_in ? SW'(SUB_SIZE) : pl32[SW-1:0];
   assign w32     = 32'(req_span_width);
   assign p_hi    = p_ff[47:16];
   assign p_lo    = p_ff[31:0];
   assign p_in    = mul_a * mul_b;

   always_comb begin
      mul_a = run_u_ff;
      mul_b = z_ff;
      case (cmd.op)
         OP_MUL_RV_U1, OP_MUL_RV_DU: mul_a = run_v_ff;
         OP_MUL_SD_V1: begin
            mul_a = depth_step_ff;
            mul_b = $signed(32'(len_ff));
         end
         OP_MUL_SU_RD: begin
            mul_a = u_step_ff;
            mul_b = $signed(32'(len_ff));
         end
         OP_MUL_SV_RU: begin
            mul_a = v_step_ff;
            mul_b = $signed(32'(len_ff));
         end
         OP_MUL_DU:    mul_a = diffu_ff;
         OP_MUL_DV_TU: mul_a = diffv_ff;
         default:      mul_a = run_u_ff;
      endcase
   end

   assign div_start = cmd.op == OP_DIV_RUN || cmd.op == OP_RV_DIV || cmd.op == OP_DIV_INV;
   assign div_round = cmd.op != OP_DIV_INV;
   assign div_num   = (cmd.op == OP_DIV_INV) ? DIV_NUM_W'(32'h0001_0000)
                                             : {depth_scale_ff, 16'h0000};
   assign div_den   = (cmd.op == OP_DIV_INV) ? $signed(32'(len_ff)) : run_depth_ff;

   psts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .round_en (div_round),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quot     (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_step_ff  <= '0;
         u_step_ff      <= '0;
         v_step_ff      <= '0;
         depth_scale_ff <= DEPTH_SCALE_RESET;
         affine_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEPTH_STEP:  depth_step_ff  <= csr_data;
            CSR_U_STEP:      u_step_ff      <= csr_data;
            CSR_V_STEP:      v_step_ff      <= csr_data;
            CSR_DEPTH_SCALE: depth_scale_ff <= csr_data;
            CSR_AFFINE_MODE: affine_ff      <= csr_data[0];
            default:         affine_ff      <= affine_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_depth_ff   <= '0;
         run_u_ff       <= '0;
         run_v_ff       <= '0;
         tex_u_ff       <= '0;
         tex_v_ff       <= '0;
         tex_du_ff      <= '0;
         tex_dv_ff      <= '0;
         pix_depth_ff   <= '0;
         pixels_left_ff <= '0;
         sub_left_ff    <= '0;
         offset_ff      <= '0;
      end else begin
         case (cmd.op)
            OP_ACCEPT: begin
               if (req_cmd == CMD_START) begin
                  pixels_left_ff <= (w32 > 32'(MAX_SPAN)) ? PW'(MAX_SPAN) : w32[PW-1:0];
                  pix_depth_ff   <= req_start_depth;
                  run_depth_ff   <= req_start_depth;
                  run_u_ff       <= req_start_u;
                  run_v_ff       <= req_start_v;
                  tex_u_ff       <= req_start_u;
                  tex_v_ff       <= req_start_v;
                  tex_du_ff      <= '0;
                  tex_dv_ff      <= '0;
                  sub_left_ff    <= '0;
                  offset_ff      <= '0;
               end
            end
            OP_MUL_SU_RD: run_depth_ff <= run_depth_ff + p_lo;
            OP_MUL_SV_RU: run_u_ff     <= run_u_ff + p_lo;
            OP_RV_DIV:    run_v_ff     <= run_v_ff + p_lo;
            OP_SHIFT: begin
               tex_du_ff   <= diffu_ff >>> SUB_SHIFT;
               tex_dv_ff   <= diffv_ff >>> SUB_SHIFT;
               tex_u_ff    <= u1_ff;
               tex_v_ff    <= v1_ff;
               sub_left_ff <= len_ff;
            end
            OP_MUL_DV_TU: tex_du_ff <= p_hi;
            OP_SETV: begin
               tex_dv_ff   <= p_hi;
               tex_u_ff    <= u1_ff;
               tex_v_ff    <= v1_ff;
               sub_left_ff <= len_ff;
            end
            OP_EMIT: begin
               if (affine_ff) begin
                  tex_u_ff <= tex_u_ff + u_step_ff;
                  tex_v_ff <= tex_v_ff + v_step_ff;
               end else begin
                  tex_u_ff    <= tex_u_ff + tex_du_ff;
                  tex_v_ff    <= tex_v_ff + tex_dv_ff;
                  sub_left_ff <= sub_left_ff - 1'b1;
               end
               pix_depth_ff   <= pix_depth_ff + depth_step_ff;
               offset_ff      <= offset_ff + 1'b1;
               pixels_left_ff <= pixels_left_ff - 1'b1;
            end
            default: offset_ff <= offset_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            stored_ff <= req_stored_depth;
            len_ff    <= len_in;
         end
         OP_DIV_WAIT: begin
            if (div_done) begin
               z_ff <= $signed(div_quot);
            end
         end
         OP_MUL_RV_U1: u1_ff    <= p_hi;
         OP_MUL_SD_V1: v1_ff    <= p_hi;
         OP_MUL_RV_DU: diffu_ff <= p_hi - u1_ff;
         OP_DV:        diffv_ff <= p_hi - v1_ff;
         OP_EMIT: begin
            rsp_pixel_offset <= offset_ff;
            rsp_texel_x      <= tex_u_ff[TEXEL_LSB +: TEXEL_W];
            rsp_texel_y      <= tex_v_ff[TEXEL_LSB +: TEXEL_W];
            rsp_pixel_depth  <= pix_depth_ff;
            rsp_write_pixel  <= pix_depth_ff > stored_ff;
            rsp_last_pixel   <= pixels_left_ff == PW'(1);
         end
         default: stored_ff <= stored_ff;
      endcase
   end

   always_comb begin
      status.pix_empty = pixels_left_ff == '0;
      status.sub_zero  = sub_left_ff == '0;
      status.affine    = affine_ff;
      status.full_sub  = len_ff == SW'(SUB_SIZE);
      status.div_done  = div_done;
   end

endmodule

// ===== hdl/psts_ctrl.sv =====
// Controller of the span stepper: sequences the subspan correction and
// owns the channel handshakes. Uses psts_pkg.
`include "assert_macros.svh"
module psts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_cmd,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  psts_pkg::dp_status_type  status,
   output psts_pkg::dp_cmd_type     cmd
);
   import psts_pkg::*;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_RECIP1 = 5'd1;
   localparam logic [4:0] ST_WAIT1  = 5'd2;
   localparam logic [4:0] ST_MU1    = 5'd3;
   localparam logic [4:0] ST_MV1    = 5'd4;
   localparam logic [4:0] ST_SD     = 5'd5;
   localparam logic [4:0] ST_SU     = 5'd6;
   localparam logic [4:0] ST_SV     = 5'd7;
   localparam logic [4:0] ST_RECIP2 = 5'd8;
   localparam logic [4:0] ST_WAIT2  = 5'd9;
   localparam logic [4:0] ST_MU2    = 5'd10;
   localparam logic [4:0] ST_MV2    = 5'd11;
   localparam logic [4:0] ST_DIFF   = 5'd12;
   localparam logic [4:0] ST_SHIFT  = 5'd13;
   localparam logic [4:0] ST_INVDIV = 5'd14;
   localparam logic [4:0] ST_WAIT3  = 5'd15;
   localparam logic [4:0] ST_MDU    = 5'd16;
   localparam logic [4:0] ST_MDV    = 5'd17;
   localparam logic [4:0] ST_SETV   = 5'd18;
   localparam logic [4:0] ST_EMIT   = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               if (req_cmd == CMD_PIXEL && !status.pix_empty) begin
                  state_in = (!status.affine && status.sub_zero) ? ST_RECIP1 : ST_EMIT;
               end
            end
         end
         ST_RECIP1: begin
            cmd.op   = OP_DIV_RUN;
            state_in = ST_WAIT1;
         end
         ST_WAIT1: begin
            cmd.op = OP_DIV_WAIT;
            if (status.div_done) begin
               state_in = ST_MU1;
            end
         end
         ST_MU1: begin
            cmd.op   = OP_MUL_RU;
            state_in = ST_MV1;
         end
         ST_MV1: begin
            cmd.op   = OP_MUL_RV_U1;
            state_in = ST_SD;
         end
         ST_SD: begin
            cmd.op   = OP_MUL_SD_V1;
            state_in = ST_SU;
         end
         ST_SU: begin
            cmd.op   = OP_MUL_SU_RD;
            state_in = ST_SV;
         end
         ST_SV: begin
            cmd.op   = OP_MUL_SV_RU;
            state_in = ST_RECIP2;
         end
         ST_RECIP2: begin
            cmd.op   = OP_RV_DIV;
            state_in = ST_WAIT2;
         end
         ST_WAIT2: begin
            cmd.op = OP_DIV_WAIT;
            if (status.div_done) begin
               state_in = ST_MU2;
            end
         end
         ST_MU2: begin
            cmd.op   = OP_MUL_RU;
            state_in = ST_MV2;
         end
         ST_MV2: begin
            cmd.op   = OP_MUL_RV_DU;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = OP_DV;
            state_in = status.full_sub ? ST_SHIFT : ST_INVDIV;
         end
         ST_SHIFT: begin
            cmd.op   = OP_SHIFT;
            state_in = ST_EMIT;
         end
         ST_INVDIV: begin
            cmd.op   = OP_DIV_INV;
            state_in = ST_WAIT3;
         end
         ST_WAIT3: begin
            cmd.op = OP_DIV_WAIT;
            if (status.div_done) begin
               state_in = ST_MDU;
            end
         end
         ST_MDU: begin
            cmd.op   = OP_MUL_DU;
            state_in = ST_MDV;
         end
         ST_MDV: begin
            cmd.op   = OP_MUL_DV_TU;
            state_in = ST_SETV;
         end
         ST_SETV: begin
            cmd.op   = OP_SETV;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_EMIT) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_SAME(a_emit_free, cmd.op == OP_EMIT, !(rsp_valid_ff && rsp_stall), "beat overwritten")
   `ASSERT_NEXT(a_emit_valid, cmd.op == OP_EMIT, rsp_valid_ff, "emitted beat not shown")
   `ASSERT_SAME(a_accept_idle, cmd.op == OP_ACCEPT, state_ff == ST_IDLE && req_valid, "bad accept")

endmodule

// ===== hdl/perspective_span_texel_stepper.sv =====
// Top level of the perspective span texel stepper.
// Joins psts_ctrl and psts_dp; uses psts_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  cmd, span, start depth/u/v, stored depth
//   rsp      out        rsp_valid/rsp_stall  offset, texel x/y, depth, write, last
//   csr      in         csr_we               csr_index, csr_data
//
// Start beats are taken in the idle state; affine or mid-subspan pixels pass through
// accept and emit. A pixel opening a perspective subspan adds two divider passes
// (three for a partial subspan) plus the multiply and update states between them.
// Reset is synchronous and clears the span walk registers and counters (not the subspan
// scratch or result registers); depth_scale resets to 1.0. The result register holds a
// stalled beat; the next pixel waits in its emit state until that beat is taken.
module perspective_span_texel_stepper #(
   parameter int MAX_SPAN  = 1024,
   parameter int SUB_SHIFT = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [psts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                         csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [10:0]                         req_span_width,
   input  logic signed [31:0]                  req_start_depth,
   input  logic signed [31:0]                  req_start_u,
   input  logic signed [31:0]                  req_start_v,
   input  logic signed [31:0]                  req_stored_depth,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [psts_pkg::OFFSET_W-1:0]       rsp_pixel_offset,
   output logic [psts_pkg::TEXEL_W-1:0]        rsp_texel_x,
   output logic [psts_pkg::TEXEL_W-1:0]        rsp_texel_y,
   output logic signed [31:0]                  rsp_pixel_depth,
   output logic                                rsp_write_pixel,
   output logic                                rsp_last_pixel
);
   import psts_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   psts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   psts_dp #(
      .MAX_SPAN  (MAX_SPAN),
      .SUB_SHIFT (SUB_SHIFT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_cmd          (req_cmd),
      .req_span_width   (req_span_width),
      .req_start_depth  (req_start_depth),
      .req_start_u      (req_start_u),
      .req_start_v      (req_start_v),
      .req_stored_depth (req_stored_depth),
      .rsp_pixel_offset (rsp_pixel_offset),
      .rsp_texel_x      (rsp_texel_x),
      .rsp_texel_y      (rsp_texel_y),
      .rsp_pixel_depth  (rsp_pixel_depth),
      .rsp_write_pixel  (rsp_write_pixel),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

// ===== tb/perspective_span_texel_stepper_checker.sv =====
// Scoreboard for the perspective span texel stepper: watches csr, req and rsp beats,
// models the span walk in 16.16 fixed point and compares every rsp beat.
// Uses psts_pkg for register indexes and command codes.
module perspective_span_texel_stepper_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [psts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [10:0]                    req_span_width,
   input  logic [31:0]                    req_start_depth,
   input  logic [31:0]                    req_start_u,
   input  logic [31:0]                    req_start_v,
   input  logic [31:0]                    req_stored_depth,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [psts_pkg::OFFSET_W-1:0]  rsp_pixel_offset,
   input  logic [psts_pkg::TEXEL_W-1:0]   rsp_texel_x,
   input  logic [psts_pkg::TEXEL_W-1:0]   rsp_texel_y,
   input  logic [31:0]                    rsp_pixel_depth,
   input  logic                           rsp_write_pixel,
   input  logic                           rsp_last_pixel,
   output int                             mismatches,
   output int                             pixels_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import psts_pkg::*;

   localparam int MAX_SPAN  = 1024;
   localparam int SUB_SHIFT = 4;
   localparam int SUB_SIZE  = 1 << SUB_SHIFT;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [TEXEL_W-1:0]  tx;
      logic [TEXEL_W-1:0]  ty;
      logic [31:0]         depth;
      logic                wr;
      logic                last;
   } texel_beat_type;

   texel_beat_type texel_q[$];
   int             bad_count;

   logic [31:0] depth_step_r, u_step_r, v_step_r, scale_r;
   logic        affine_r;
   logic [31:0] acc_depth, acc_u, acc_v, cur_u, cur_v, inc_u, inc_v, cur_depth;
   logic [10:0] left_n;
   logic [7:0]  sub_n;
   logic [9:0]  offset_n;

   function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] p;
      p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
      return p[47:16];
   endfunction

   function automatic logic [31:0] fx_recip(input logic [31:0] den);
      logic signed [63:0] num, d;
      logic [63:0]        n, m, q, r;
      logic               neg;
      num = $signed({{32{scale_r[31]}}, scale_r}) <<< 16;
      d   = $signed({{32{den[31]}}, den});
      if (d == 0) return 32'h7FFF_FFFF;
      neg = num[63] ^ d[63];
      n = num[63] ? -num : num;
      m = d[63] ? -d : d;
      q = n / m;
      r = n % m;
      if (2 * r > m || (2 * r == m && q[0])) q++;
      if (!neg) return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      if (q > 64'h8000_0000) return 32'h8000_0000;
      return -q[31:0];
   endfunction

   task automatic open_subspan();
      logic [31:0] z, u1, v1, u2, v2, inv, len;
      z  = fx_recip(acc_depth);
      u1 = fx_mul(acc_u, z);
      v1 = fx_mul(acc_v, z);
      if (left_n >= SUB_SIZE) begin
         len = SUB_SIZE;
         acc_depth += depth_step_r << SUB_SHIFT;
         acc_u += u_step_r << SUB_SHIFT;
         acc_v += v_step_r << SUB_SHIFT;
         z  = fx_recip(acc_depth);
         u2 = fx_mul(acc_u, z);
         v2 = fx_mul(acc_v, z);
         inc_u = $signed(u2 - u1) >>> SUB_SHIFT;
         inc_v = $signed(v2 - v1) >>> SUB_SHIFT;
      end else begin
         len = left_n;
         acc_u += fx_mul(u_step_r, len << 16);
         acc_v += fx_mul(v_step_r, len << 16);
         acc_depth += fx_mul(depth_step_r, len << 16);
         z  = fx_recip(acc_depth);
         u2 = fx_mul(acc_u, z);
         v2 = fx_mul(acc_v, z);
         inv = 32'h1_0000 / len;
         inc_u = fx_mul(u2 - u1, inv);
         inc_v = fx_mul(v2 - v1, inv);
      end
      cur_u = u1;
      cur_v = v1;
      sub_n = len[7:0];
   endtask

   task automatic walk_pixel(input logic [31:0] stored);
      texel_beat_type e;
      if (left_n == 0) return;
      if (!affine_r && sub_n == 0) open_subspan();
      e.offset = offset_n;
      e.tx     = cur_u[TEXEL_LSB +: TEXEL_W];
      e.ty     = cur_v[TEXEL_LSB +: TEXEL_W];
      e.depth  = cur_depth;
      e.wr     = $signed(cur_depth) > $signed(stored);
      e.last   = (left_n == 1);
      texel_q.push_back(e);
      if (affine_r) begin
         cur_u += u_step_r;
         cur_v += v_step_r;
      end else begin
         cur_u += inc_u;
         cur_v += inc_v;
         sub_n--;
      end
      cur_depth += depth_step_r;
      offset_n++;
      left_n--;
   endtask

   always @(posedge clock) begin
      texel_beat_type got, want;
      if (reset) begin
         depth_step_r = '0; u_step_r = '0; v_step_r = '0;
         scale_r = DEPTH_SCALE_RESET; affine_r = 1'b0;
         acc_depth = '0; acc_u = '0; acc_v = '0;
         cur_u = '0; cur_v = '0; inc_u = '0; inc_v = '0; cur_depth = '0;
         left_n = '0; sub_n = '0; offset_n = '0;
         texel_q.delete();
         bad_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEPTH_STEP:  depth_step_r = csr_data;
               CSR_U_STEP:      u_step_r = csr_data;
               CSR_V_STEP:      v_step_r = csr_data;
               CSR_DEPTH_SCALE: scale_r = csr_data;
               CSR_AFFINE_MODE: affine_r = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_pixel_offset, rsp_texel_x, rsp_texel_y, rsp_pixel_depth,
                    rsp_write_pixel, rsp_last_pixel};
            if (texel_q.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("unexpected rsp beat: offset %0d depth %h", got.offset, got.depth);
            end else begin
               want = texel_q.pop_front();
               if (got !== want) begin
                  bad_count++;
                  if (bad_count <= 10)
                     $display({"rsp mismatch: exp off %0d tx %0d ty %0d z %h wr %b last %b",
                               " / got off %0d tx %0d ty %0d z %h wr %b last %b"},
                              want.offset, want.tx, want.ty, want.depth, want.wr, want.last,
                              got.offset, got.tx, got.ty, got.depth, got.wr, got.last);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_START) begin
               left_n    = (req_span_width > MAX_SPAN) ? 11'(MAX_SPAN) : req_span_width;
               cur_depth = req_start_depth;
               acc_depth = req_start_depth;
               acc_u = req_start_u;
               acc_v = req_start_v;
               cur_u = acc_u;
               cur_v = acc_v;
               inc_u = '0;
               inc_v = '0;
               sub_n = '0;
               offset_n = '0;
            end else begin
               walk_pixel(req_stored_depth);
            end
         end
      end
      mismatches     <= bad_count;
      pixels_pending <= texel_q.size();
   end
endmodule

// ===== tb/perspective_span_texel_stepper_tb.sv =====
// Testbench top for the perspective span texel stepper: drives csr writes and span/pixel
// beats with random idling and stalls; the checker module predicts and compares.
// Depends on psts_pkg, perspective_span_texel_stepper and its checker.
module perspective_span_texel_stepper_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import psts_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_cmd = CMD_START;
   logic [10:0]          req_span_width = '0;
   logic signed [31:0]   req_start_depth = '0;
   logic signed [31:0]   req_start_u = '0;
   logic signed [31:0]   req_start_v = '0;
   logic signed [31:0]   req_stored_depth = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [OFFSET_W-1:0]  rsp_pixel_offset;
   logic [TEXEL_W-1:0]   rsp_texel_x;
   logic [TEXEL_W-1:0]   rsp_texel_y;
   logic signed [31:0]   rsp_pixel_depth;
   logic                 rsp_write_pixel;
   logic                 rsp_last_pixel;

   int mismatches;
   int pixels_pending;
   bit quiet = 1'b0;
   bit hold_go = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   perspective_span_texel_stepper uut (.*);
   perspective_span_texel_stepper_checker chk (.*);

   initial begin
      #20ms;
      $display("perspective_span_texel_stepper verification failed");
      $finish;
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && !reset && $urandom_range(0, 6) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_beat(input logic cmd, input logic [10:0] w, input logic [31:0] sd,
                            input logic [31:0] su, input logic [31:0] sv,
                            input logic [31:0] st);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_span_width   <= w;
      req_start_depth  <= sd;
      req_start_u      <= su;
      req_start_v      <= sv;
      req_stored_depth <= st;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic load_regs(input logic [31:0] dz, input logic [31:0] du,
                            input logic [31:0] dv, input logic [31:0] scale,
                            input logic affine);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_DEPTH_STEP;  csr_data <= dz;   @(posedge clock);
      csr_index <= CSR_U_STEP;      csr_data <= du;   @(posedge clock);
      csr_index <= CSR_V_STEP;      csr_data <= dv;   @(posedge clock);
      csr_index <= CSR_DEPTH_SCALE; csr_data <= scale; @(posedge clock);
      csr_index <= CSR_AFFINE_MODE; csr_data <= {31'b0, affine}; @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] step_val();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 4096)) - 2048);
         default: return 32'($signed($urandom_range(0, 'h4_0000)) - 'h2_0000);
      endcase
   endfunction

   task automatic run_span(input logic [10:0] w);
      logic [31:0] z0;
      z0 = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range('h1000, 'h40_0000);
      send_beat(CMD_START, w, z0, $urandom, $urandom, $urandom);
      for (int i = 0; i < w + $urandom_range(0, 2); i++)
         send_beat(CMD_PIXEL, 11'($urandom), $urandom, $urandom, $urandom,
                   ($urandom_range(0, 1)) ? $urandom : z0 + $urandom_range(0, 'h2000) - 'h1000);
   endtask

   initial begin
      logic [10:0] w;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_regs(32'h0000_0800, 32'h0000_4000, 32'hFFFF_C000, DEPTH_SCALE_RESET, 1'b0);
      send_beat(CMD_START, 11'h7FF, 32'h0010_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_beat(CMD_PIXEL, '0, '0, '0, '0, 32'h8000_0000);
      send_beat(CMD_PIXEL, '0, '0, '0, '0, 32'h7FFF_FFFF);
      send_beat(CMD_START, 11'd0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_beat(CMD_PIXEL, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_beat(CMD_START, 11'd1, 32'h8000_0000, 32'h0123_4567, 32'hFEDC_BA98, 32'h0);
      send_beat(CMD_PIXEL, '0, '0, '0, '0, 32'h0);
      send_beat(CMD_PIXEL, '0, '0, '0, '0, 32'h0);
      send_beat(CMD_START, 11'd5, 32'h0, 32'h0020_0000, 32'h0030_0000, 32'h0);
      repeat (5) send_beat(CMD_PIXEL, '0, '0, '0, '0, 32'hFFFF_0000);
      send_beat(CMD_START, 11'd18, 32'h0000_0001, 32'h4000_0000, 32'hC000_0000, 32'h0);
      repeat (3) send_beat(CMD_PIXEL, '0, '0, '0, '0, 32'h0);
      // switch to affine mid span with a saturating scale, then back to perspective
      load_regs(32'hFFFF_FFFF, 32'h0002_0000, 32'hFFFE_0000, 32'h7FFF_FFFF, 1'b1);
      repeat (3) send_beat(CMD_PIXEL, '0, '0, '0, '0, 32'h0);
      load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      repeat (4) send_beat(CMD_PIXEL, '0, '0, '0, '0, 32'h0);

      for (int p = 0; p < 12; p++) begin
         int issued;
         quiet = (p >= 10);
         case (p)
            1: load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
            2: load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
            3: load_regs(step_val(), step_val(), step_val(), 32'h0, 1'b0);
            default: load_regs(step_val(), step_val(), step_val(),
                               ($urandom_range(0, 2) == 0) ? $urandom : DEPTH_SCALE_RESET,
                               $urandom_range(0, 2) == 0);
         endcase
         if (p == 4) begin
            hold_go = 1'b1;
            run_span(11'd60);
         end
         if (p == 6) run_span(11'd200);
         issued = 0;
         while (issued < 50) begin
            if ($urandom_range(0, 9) == 0) begin
               send_beat(1'($urandom_range(0, 1)), 11'($urandom), $urandom, $urandom,
                         $urandom, $urandom);
               issued++;
            end else begin
               w = ($urandom_range(0, 15) == 0) ? 11'($urandom) : 11'($urandom_range(0, 40));
               if (w > 200) w = 11'($urandom_range(1025, 2047));
               run_span(w > 1024 ? 11'd40 : w);
               if (w > 1024) send_beat(CMD_START, w, $urandom, $urandom, $urandom, $urandom);
               issued += w > 1024 ? 41 : w + 1;
            end
            if (p == 5 && issued < 40) drain();
         end
      end
      drain();
      if (mismatches == 0 && pixels_pending == 0)
         $display("perspective_span_texel_stepper verification clean");
      else
         $display("perspective_span_texel_stepper verification failed");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/psts_pkg.sv
hdl/psts_div.sv
hdl/psts_dp.sv
hdl/psts_ctrl.sv
hdl/perspective_span_texel_stepper.sv
tb/perspective_span_texel_stepper_checker.sv
tb/perspective_span_texel_stepper_tb.sv
